[hw/rtl/itoa_pkg.sv]
`default_nettype none

package itoa_pkg;

    localparam int unsigned STEP_BITS = 8;    // quotient bits resolved per divide cycle

    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [4:0] DECIMAL_BASE  = 5'd10;
    localparam logic [4:0] RADIX_MIN     = 5'd2;
    localparam logic [4:0] RADIX_MAX     = 5'd16;
    localparam logic [4:0] RADIX_RESET   = 5'd10;

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_PREP = 4'b0100,
        ST_EMIT = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;   // capture a new value
        logic div;    // run one batch of divide steps
        logic prep;   // point the read index at the top digit
        logic emit;   // load the next character into the output register
    } t_cmd;

    typedef struct packed {
        logic step_last;  // this divide cycle finishes a digit
        logic next_zero;  // quotient after this cycle is zero
        logic cnt_full;   // digit being written is the last one that fits
        logic idx_zero;   // read index is at the least significant digit
        logic sign;       // a '-' is still to be sent
        logic out_free;   // output register can take a character this cycle
    } t_status;

    function automatic logic [7:0] digit_to_ascii(input logic [3:0] d);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = ASCII_ZERO + {4'd0, d};
        end else begin
            c = ASCII_UPPER_A + {4'd0, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/itoa_ctrl.sv]
`default_nettype none

module itoa_ctrl
    import itoa_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  wire t_status i_status,
    output t_cmd         o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        o_s_axis_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_axis_tready = 1'b1;
                if (i_s_axis_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_DIV;
                end
            end
            ST_DIV: begin
                o_cmd.div = 1'b1;
                if (i_status.step_last && (i_status.next_zero || i_status.cnt_full)) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                o_cmd.prep = 1'b1;
                n_state    = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (!i_status.sign && i_status.idx_zero) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

[hw/rtl/itoa_dp.sv]
`default_nettype none

module itoa_dp
    import itoa_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_wr_en,
    input  wire logic [4:0]             i_cfg_wr_data,
    input  wire logic [VALUE_WIDTH-1:0] i_value,
    input  wire t_cmd                   i_cmd,
    output t_status                     o_status,
    input  wire logic                   i_m_axis_tready,
    output logic                        o_m_axis_tvalid,
    output logic [7:0]                  o_m_axis_tdata,
    output logic                        o_m_axis_tlast
);

    localparam int unsigned QW    = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
    localparam int unsigned NSTEP = QW / STEP_BITS;
    localparam int unsigned SW    = (NSTEP > 1) ? $clog2(NSTEP) : 1;
    localparam int unsigned IW    = $clog2(VALUE_WIDTH);
    localparam int unsigned CW    = $clog2(VALUE_WIDTH + 1);

    logic [4:0]    r_radix;
    logic [QW-1:0] r_quo, n_quo;
    logic [3:0]    r_rem, n_rem;
    logic [SW-1:0] r_step;
    logic [CW-1:0] r_cnt;
    logic [IW-1:0] r_idx, n_idx;
    logic          r_sign;
    logic [3:0]    r_digit_mem [VALUE_WIDTH];
    logic [3:0]    r_rd_digit;
    logic          r_out_valid;
    logic [7:0]    r_out_char;
    logic          r_out_last;
    logic          neg_dec;
    logic [VALUE_WIDTH-1:0] abs_value;

    // saturate to 2..16 on write; only the effective base is ever used
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix <= RADIX_RESET;
        end else if (i_cfg_wr_en) begin
            if (i_cfg_wr_data < RADIX_MIN) begin
                r_radix <= RADIX_MIN;
            end else if (i_cfg_wr_data > RADIX_MAX) begin
                r_radix <= RADIX_MAX;
            end else begin
                r_radix <= i_cfg_wr_data;
            end
        end
    end

    assign neg_dec   = i_value[VALUE_WIDTH-1] && (r_radix == DECIMAL_BASE);
    assign abs_value = neg_dec ? (~i_value + 1'b1) : i_value;

    // restoring division, STEP_BITS quotient bits per cycle, MSB first
    always_comb begin
        logic [4:0]    rem;
        logic [QW-1:0] q;
        rem = {1'b0, r_rem};
        q   = r_quo;
        for (int i = 0; i < STEP_BITS; i++) begin
            rem = {rem[3:0], q[QW-1]};
            q   = {q[QW-2:0], 1'b0};
            if (rem >= r_radix) begin
                rem  = rem - r_radix;
                q[0] = 1'b1;
            end
        end
        n_rem = rem[3:0];
        n_quo = q;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quo  <= QW'(abs_value);
            r_rem  <= '0;
            r_step <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.div) begin
            r_quo <= n_quo;
            if (o_status.step_last) begin
                r_rem  <= '0;
                r_step <= '0;
                r_cnt  <= r_cnt + 1'b1;
            end else begin
                r_rem  <= n_rem;
                r_step <= r_step + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.div && o_status.step_last) begin
            r_digit_mem[r_cnt[IW-1:0]] <= n_rem;
        end
    end

    // read address follows the next index so r_rd_digit matches r_idx while digits are read out
    always_comb begin
        n_idx = r_idx;
        if (i_cmd.prep) begin
            n_idx = IW'(r_cnt - 1'b1);
        end else if (i_cmd.emit && !r_sign) begin
            n_idx = r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx      <= n_idx;
        r_rd_digit <= r_digit_mem[n_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sign <= 1'b0;
        end else if (i_cmd.load) begin
            r_sign <= neg_dec;
        end else if (i_cmd.emit) begin
            r_sign <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            if (r_sign) begin
                r_out_char <= ASCII_MINUS;
                r_out_last <= 1'b0;
            end else begin
                r_out_char <= digit_to_ascii(r_rd_digit);
                r_out_last <= (r_idx == '0);
            end
        end
    end

    always_comb begin
        o_status.step_last = (r_step == SW'(NSTEP - 1));
        o_status.next_zero = (n_quo == '0);
        o_status.cnt_full  = (r_cnt == CW'(VALUE_WIDTH - 1));
        o_status.idx_zero  = (r_idx == '0);
        o_status.sign      = r_sign;
        o_status.out_free  = !r_out_valid || i_m_axis_tready;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_char;
    assign o_m_axis_tlast  = r_out_last;

endmodule

`default_nettype wire

[hw/rtl/int_to_ascii_radix_top.sv]
// Integer to ASCII converter, base 2 to 16.
// Input stream: one signed VALUE_WIDTH-bit value per transfer in s_axis_tdata.
// Output stream: one ASCII character per transfer, most significant digit
// first, tlast on the final character. Digits above 9 are 'A'..'F'. In base
// 10 a negative value is preceded by '-'; in other bases a negative value is
// printed as its two's-complement bit pattern. Zero prints as "0".
// Base is set through i_cfg_wr_en / i_cfg_wr_data (reset 10, values outside
// 2..16 clamp to the nearest end); write it only while the block is idle.
// The divider resolves 8 quotient bits per cycle. An item is accepted, then
// divided one digit at a time, least significant first, then the read index
// is set up and the characters are sent, sign first, as the receiver takes
// them; a 32-bit value in base 10 gives at most 11 characters.
// s_axis_tready is high only between items; the last character can still sit
// in the output register while the next value is taken.
// A stalled receiver holds the output register and pauses character output.
// Reset (synchronous, active low) empties the output, returns to idle and sets
// the base to 10.
`default_nettype none

module int_to_ascii_radix_top
    import itoa_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_cfg_wr_en,
    input  wire logic [4:0]                             i_cfg_wr_data,  // radix
    input  wire logic                                   i_s_axis_tvalid,
    output logic                                        o_s_axis_tready,
    input  wire logic [((VALUE_WIDTH + 7) / 8) * 8-1:0] i_s_axis_tdata, // value
    output logic                                        o_m_axis_tvalid,
    input  wire logic                                   i_m_axis_tready,
    output logic [7:0]                                  o_m_axis_tdata, // character
    output logic                                        o_m_axis_tlast
);

    t_cmd    cmd;
    t_status status;

    itoa_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_status        (status),
        .o_cmd           (cmd)
    );

    itoa_dp #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_value         (i_s_axis_tdata[VALUE_WIDTH-1:0]),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

`default_nettype wire

[hw/rtl/itoa_checker.sv]
`default_nettype none

module itoa_checker
    import itoa_pkg::*;
(
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_s_axis_tvalid,
    input wire logic       o_s_axis_tready,
    input wire logic       o_m_axis_tvalid,
    input wire logic       i_m_axis_tready,
    input wire logic [7:0] o_m_axis_tdata,
    input wire logic       o_m_axis_tlast
);

    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output changed");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input ready while converting");

    a_legal_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata >= ASCII_ZERO && o_m_axis_tdata <= 8'h39) ||
            (o_m_axis_tdata >= ASCII_UPPER_A && o_m_axis_tdata <= 8'h46) ||
            (o_m_axis_tdata == ASCII_MINUS))
        else $error("illegal character code");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tdata == ASCII_MINUS) |-> !o_m_axis_tlast)
        else $error("sign flagged as last character");

endmodule

bind int_to_ascii_radix_top itoa_checker u_itoa_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tlast  (o_m_axis_tlast)
);

`default_nettype wire

[tb/int_to_ascii_radix_checker.sv]
`timescale 1ns / 1ps

// Watches both streams and the radix register. Each accepted value is
// expanded into its expected characters; every character leaving the block
// is checked against the oldest one waiting.
module int_to_ascii_radix_checker
    import itoa_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [4:0]  i_cfg_wr_data,
    input  wire logic        i_s_axis_tvalid,
    input  wire logic        i_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,
    input  wire logic        i_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    input  wire logic [7:0]  i_m_axis_tdata,
    input  wire logic        i_m_axis_tlast,
    output int               o_mismatch_count,
    output int               o_pending
);

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    t_text_char expected_chars[$];
    logic [4:0] radix_reg;

    // Expand one value into the characters the block must send.
    function automatic void expand_value(input logic [31:0] value,
                                         input logic [4:0] radix_sel);
        logic [4:0]  base;
        logic [31:0] mag;
        logic [3:0]  digits[32];
        logic [7:0]  code;
        logic        minus;
        int          n;
        base = (radix_sel < RADIX_MIN) ? RADIX_MIN :
               (radix_sel > RADIX_MAX) ? RADIX_MAX : radix_sel;
        minus = value[31] && (base == DECIMAL_BASE);
        // unsigned negate also covers the most negative value
        mag = minus ? (~value + 32'd1) : value;
        n = 0;
        do begin
            digits[n] = 4'(mag % {27'd0, base});
            mag = mag / {27'd0, base};
            n++;
        end while (mag != 0 && n < 32);
        if (minus) begin
            expected_chars.push_back('{ch: ASCII_MINUS, last: 1'b0});
        end
        for (int i = n - 1; i >= 0; i--) begin
            if (digits[i] < 4'd10) begin
                code = ASCII_ZERO + {4'd0, digits[i]};
            end else begin
                code = ASCII_UPPER_A + {4'd0, digits[i] - 4'd10};
            end
            expected_chars.push_back('{ch: code, last: (i == 0)});
        end
    endfunction

    always @(posedge i_clk) begin
        t_text_char exp_char;
        if (!i_rst_n) begin
            expected_chars.delete();
            radix_reg = RADIX_RESET;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_chars.size() == 0) begin
                    if (o_mismatch_count < 10) begin
                        $display("%0t: unexpected character 0x%02h last=%0b",
                                 $realtime, i_m_axis_tdata, i_m_axis_tlast);
                    end
                    o_mismatch_count++;
                end else begin
                    exp_char = expected_chars.pop_front();
                    if (i_m_axis_tdata !== exp_char.ch ||
                        i_m_axis_tlast !== exp_char.last) begin
                        if (o_mismatch_count < 10) begin
                            $display({"%0t: character mismatch: expected 0x%02h last=%0b,",
                                      " got 0x%02h last=%0b"},
                                     $realtime, exp_char.ch, exp_char.last,
                                     i_m_axis_tdata, i_m_axis_tlast);
                        end
                        o_mismatch_count++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                expand_value(i_s_axis_tdata, radix_reg);
            end
            if (i_cfg_wr_en) begin
                radix_reg = i_cfg_wr_data;
            end
        end
        o_pending <= expected_chars.size();
    end

endmodule

[tb/int_to_ascii_radix_top_tb.sv]
`timescale 1ns / 1ps

module int_to_ascii_radix_top_tb
    import itoa_pkg::*;
;

    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;
    localparam int NUM_PHASES = 10;
    localparam int ITEMS_PER_PHASE = 44;
    localparam int NUM_DIRECTED = 23;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_wr_en;
    logic [4:0]  i_cfg_wr_data;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [31:0] i_s_axis_tdata;    // value
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [7:0]  o_m_axis_tdata;    // character
    logic        o_m_axis_tlast;

    int   mismatch_count;
    int   pending_chars;
    logic no_idle;
    logic hold_req;
    logic hold_done;

    int_to_ascii_radix_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    int_to_ascii_radix_checker checker_inst (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data),
        .i_s_axis_tvalid  (i_s_axis_tvalid),
        .i_s_axis_tready  (o_s_axis_tready),
        .i_s_axis_tdata   (i_s_axis_tdata),
        .i_m_axis_tvalid  (o_m_axis_tvalid),
        .i_m_axis_tready  (i_m_axis_tready),
        .i_m_axis_tdata   (o_m_axis_tdata),
        .i_m_axis_tlast   (o_m_axis_tlast),
        .o_mismatch_count (mismatch_count),
        .o_pending        (pending_chars)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // directed values, paired with the radix in force for each
    logic [4:0]  directed_radix[NUM_DIRECTED] = '{
        5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10, 5'd10,
        5'd16, 5'd16, 5'd16, 5'd16, 5'd16,
        5'd2, 5'd2, 5'd2,
        5'd0, 5'd0,
        5'd31, 5'd31,
        5'd17,
        5'd1
    };
    logic [31:0] directed_value[NUM_DIRECTED] = '{
        32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6,
        32'h7FFF_FFFF, 32'h8000_0000, 32'd1000000000,
        32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFEDC_BA98, 32'h0ABC_DEF0,
        32'hFFFF_FFFF, 32'd0, 32'd5,
        32'd6, 32'hFFFF_FFFE,
        32'd255, 32'hFFFF_FFFF,
        32'h0000_001F,
        32'd3
    };

    function automatic logic [31:0] pick_value();
        logic [31:0] v;
        case ($urandom_range(0, 7))
            3: begin
                v = 32'($urandom_range(0, 40));
                if ($urandom_range(0, 1)) v = -v;
            end
            4: v = (32'd1 << $urandom_range(0, 31)) + 32'($urandom_range(0, 2)) - 32'd1;
            5: begin
                v = $urandom >> $urandom_range(1, 31);
                if ($urandom_range(0, 1)) v = -v;
            end
            6: begin
                case ($urandom_range(0, 3))
                    0: v = 32'd0;
                    1: v = 32'h8000_0000;
                    2: v = 32'h7FFF_FFFF;
                    default: v = 32'hFFFF_FFFF;
                endcase
            end
            7: v = -($urandom >> $urandom_range(0, 28));
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_value(input logic [31:0] v);
        if (!no_idle && $urandom_range(0, 99) < 12) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= v;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    // Let every expected character drain, then let the block settle.
    task automatic drain_output();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_chars != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_radix(input logic [4:0] r);
        drain_output();
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= r;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // Receiver: random backpressure plus one long hold-off to fill the block.
    initial begin
        int hold_cnt;
        hold_done = 1'b0;
        i_m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                i_m_axis_tready <= 1'b0;
                hold_done = 1'b1;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++) @(posedge i_clk);
            end
            i_m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 12);
        end
    end

    initial begin
        logic [4:0] cur_radix;
        logic [4:0] phase_radix;
        i_rst_n <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_wr_data <= RADIX_RESET;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata <= '0;
        no_idle <= 1'b0;
        hold_req <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        cur_radix = RADIX_RESET;
        for (int i = 0; i < NUM_DIRECTED; i++) begin
            if (directed_radix[i] != cur_radix) begin
                cur_radix = directed_radix[i];
                write_radix(cur_radix);
            end
            send_value(directed_value[i]);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                0: phase_radix = 5'd10;
                1: phase_radix = 5'd2;
                2: phase_radix = 5'd16;
                3: phase_radix = 5'd8;
                4: phase_radix = 5'd3;
                5: phase_radix = 5'd31;
                default: phase_radix = 5'($urandom_range(0, 31));
            endcase
            write_radix(phase_radix);
            no_idle <= (p == 3);
            // long receiver stall while the sender keeps offering values
            if (p == 1) hold_req <= 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
                send_value(pick_value());
            end
        end

        drain_output();
        if (mismatch_count == 0 && pending_chars == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/itoa_pkg.sv
hw/rtl/itoa_ctrl.sv
hw/rtl/itoa_dp.sv
hw/rtl/int_to_ascii_radix_top.sv
hw/rtl/itoa_checker.sv
tb/int_to_ascii_radix_checker.sv
tb/int_to_ascii_radix_top_tb.sv
